[sv/tphq_pkg.sv]
// ---------------------------------------------------------------------------
// tphq_pkg
// shared constants, codes and types of the terrain plane height query block
// ---------------------------------------------------------------------------
package tphq_pkg;

  localparam int MAX_STRIPS     = 256;
  localparam int ACCESS_DEPTH   = 4096;
  localparam int PLATE_DEPTH    = 1024;
  localparam int POINT_DEPTH    = 1024;
  localparam int SLOPE_DEPTH    = 256;
  localparam int MAX_CANDIDATES = 10;

  localparam int STRIP_AW = $clog2(MAX_STRIPS);
  localparam int ACC_AW   = $clog2(ACCESS_DEPTH);
  localparam int PLATE_AW = $clog2(PLATE_DEPTH);
  localparam int POINT_AW = $clog2(POINT_DEPTH);
  localparam int SLOPE_AW = $clog2(SLOPE_DEPTH);
  localparam int CNT_W    = $clog2(ACCESS_DEPTH + 1);
  localparam int HIT_W    = $clog2(MAX_CANDIDATES + 1);
  localparam int SCNT_W   = 9;
  localparam int BS_W     = $clog2(MAX_STRIPS + 1);

  // request type codes
  localparam logic [2:0] REQ_QUERY  = 3'd0;
  localparam logic [2:0] REQ_STRIP  = 3'd1;
  localparam logic [2:0] REQ_ACCESS = 3'd2;
  localparam logic [2:0] REQ_PLATE  = 3'd3;
  localparam logic [2:0] REQ_POINT  = 3'd4;
  localparam logic [2:0] REQ_SLOPE  = 3'd5;
  localparam logic [2:0] REQ_HEIGHT = 3'd6;
  localparam logic [2:0] REQ_NONE   = 3'd7;

  // item classes from the front end
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // configuration register indexes
  localparam logic CFG_MAP_LOADED  = 1'b0;
  localparam logic CFG_STRIP_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [1:0]         kind;
    logic [11:0]        idx;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [9:0]         d;
  } req_t;

  typedef struct packed {
    logic [ACC_AW-1:0] start;
    logic [CNT_W-1:0]  count;
  } range_t;

  typedef struct packed {
    logic [POINT_AW-1:0] p0;
    logic [POINT_AW-1:0] p1;
    logic [SLOPE_AW-1:0] slope;
    logic [PLATE_AW-1:0] height;
  } plate_t;

endpackage

[sv/tphq_ifs.sv]
// ---------------------------------------------------------------------------
// tphq channel interfaces
// request, result and configuration channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface tphq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [11:0]        entry_index;
  logic signed [31:0] word_a;
  logic signed [31:0] word_b;
  logic signed [31:0] word_c;
  logic [9:0]         word_d;
  modport source (output valid, req_type, entry_index, word_a, word_b, word_c, word_d,
                  input ready);
  modport sink (input valid, req_type, entry_index, word_a, word_b, word_c, word_d,
                output ready);
endinterface

interface tphq_res_if;
  logic               valid;
  logic               ready;
  logic               height_found;
  logic signed [31:0] new_height;
  modport source (output valid, height_found, new_height, input ready);
  modport sink (input valid, height_found, new_height, output ready);
endinterface

interface tphq_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/tphq_ram.sv]
// ---------------------------------------------------------------------------
// tphq_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module tphq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/tphq_front.sv]
// ---------------------------------------------------------------------------
// tphq_front
// accepts items, classifies them and holds them in a two-entry queue
// ---------------------------------------------------------------------------
module tphq_front (
  input  logic          clk,
  input  logic          rst_n,
  tphq_req_if.sink      in_ch,
  output tphq_pkg::req_t q_req,
  output logic          q_valid,
  input  logic          q_pop
);
  import tphq_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  req_t       cls;
  logic       push;

  // classify: unknown type or out-of-range write index means no effect
  always_comb begin
    cls          = '0;
    cls.req_type = in_ch.req_type;
    cls.idx      = in_ch.entry_index;
    cls.a        = in_ch.word_a;
    cls.b        = in_ch.word_b;
    cls.c        = in_ch.word_c;
    cls.d        = in_ch.word_d;
    unique case (in_ch.req_type)
      REQ_QUERY: cls.kind = KIND_QUERY;
      REQ_STRIP, REQ_SLOPE:
        cls.kind = (32'(in_ch.entry_index) < 32'((in_ch.req_type == REQ_STRIP) ?
                    MAX_STRIPS : SLOPE_DEPTH)) ? KIND_WRITE : KIND_NONE;
      REQ_ACCESS:
        cls.kind = (32'(in_ch.entry_index) < 32'(ACCESS_DEPTH)) ? KIND_WRITE : KIND_NONE;
      REQ_PLATE, REQ_HEIGHT:
        cls.kind = (32'(in_ch.entry_index) < 32'(PLATE_DEPTH)) ? KIND_WRITE : KIND_NONE;
      REQ_POINT:
        cls.kind = (32'(in_ch.entry_index) < 32'(POINT_DEPTH)) ? KIND_WRITE : KIND_NONE;
      default: cls.kind = KIND_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_req       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

[sv/tphq_back.sv]
// ---------------------------------------------------------------------------
// tphq_back
// table storage and query engine: strip search, plate scan, plane solve
// ---------------------------------------------------------------------------
module tphq_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tphq_pkg::req_t            q_req,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic                      map_loaded,
  input  logic [tphq_pkg::SCNT_W-1:0] strip_count,
  tphq_res_if.source                out_ch
);
  import tphq_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_QSTART = 5'd1;
  localparam logic [4:0] S_BS_RD  = 5'd2;
  localparam logic [4:0] S_BS_CMP = 5'd3;
  localparam logic [4:0] S_RNG_RD = 5'd4;
  localparam logic [4:0] S_RNG    = 5'd5;
  localparam logic [4:0] S_CHK    = 5'd6;
  localparam logic [4:0] S_ACC    = 5'd7;
  localparam logic [4:0] S_PLT    = 5'd8;
  localparam logic [4:0] S_PT0    = 5'd9;
  localparam logic [4:0] S_PT1    = 5'd10;
  localparam logic [4:0] S_BOX    = 5'd11;
  localparam logic [4:0] S_MUL1   = 5'd12;
  localparam logic [4:0] S_MUL2   = 5'd13;
  localparam logic [4:0] S_SUM    = 5'd14;
  localparam logic [4:0] S_DIVI   = 5'd15;
  localparam logic [4:0] S_DIV    = 5'd16;
  localparam logic [4:0] S_DIVF   = 5'd17;
  localparam logic [4:0] S_CAND   = 5'd18;

  localparam int DVD_W = 44;

  function automatic logic signed [31:0] fx_round(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd2048;
    return $signed(t[43:12]);
  endfunction

  logic [4:0] state_r;

  // query operands
  logic signed [31:0] cur_r, x_r, z_r;
  logic [BS_W-1:0]    low_r, high_r, mid_r;
  logic [STRIP_AW-1:0] s_r;
  logic [ACC_AW-1:0]  start_r;
  logic [CNT_W-1:0]   cnt_r, i_r;
  logic [HIT_W-1:0]   hits_r;
  plate_t             plate_r;
  logic signed [31:0] pt0x_r, pt0z_r, sx_r, sz_r, sy_r, off_r;
  logic signed [63:0] prod1_r, prod2_r;
  logic signed [31:0] num_r, cand_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [31:0]        rem_r, dmag_r;
  logic [5:0]         dcnt_r;
  logic               qneg_r;
  logic [32:0]        best_dist_r;
  logic signed [31:0] best_r;

  // result register
  logic               out_valid_r, found_r;
  logic signed [31:0] height_r;

  // ram ports
  logic               wr_en;
  logic [31:0]        bnd_rdata;
  range_t             rng_rdata, rng_wdata;
  logic [PLATE_AW-1:0] acc_rdata;
  plate_t             plt_rdata, plt_wdata;
  logic [63:0]        pt_rdata, sxz_rdata;
  logic [31:0]        sup_rdata, off_rdata;
  logic [POINT_AW-1:0] pt_raddr;
  logic [ACC_AW-1:0]  acc_raddr;

  assign q_pop = (state_r == S_IDLE) && q_valid &&
                 ((q_req.kind != KIND_QUERY) || !out_valid_r);
  assign wr_en = q_pop && (q_req.kind == KIND_WRITE);

  // write data formatting
  always_comb begin
    rng_wdata.start = q_req.b[ACC_AW-1:0];
    if (q_req.c < 0) begin
      rng_wdata.count = '0;
    end else if (q_req.c > 32'sd0 + ACCESS_DEPTH) begin
      rng_wdata.count = CNT_W'(ACCESS_DEPTH);
    end else begin
      rng_wdata.count = q_req.c[CNT_W-1:0];
    end
    plt_wdata.p0     = q_req.a[POINT_AW-1:0];
    plt_wdata.p1     = q_req.b[POINT_AW-1:0];
    plt_wdata.slope  = q_req.c[SLOPE_AW-1:0];
    plt_wdata.height = q_req.d[PLATE_AW-1:0];
  end

  assign pt_raddr  = (state_r == S_PT0) ? plt_rdata.p0 : plate_r.p1;
  assign acc_raddr = start_r + i_r[ACC_AW-1:0];

  tphq_ram #(.WIDTH(32), .DEPTH(MAX_STRIPS)) u_bounds (
    .clk, .we(wr_en && q_req.req_type == REQ_STRIP), .waddr(q_req.idx[STRIP_AW-1:0]),
    .wdata(q_req.a), .raddr(mid_r[STRIP_AW-1:0]), .rdata(bnd_rdata));
  tphq_ram #(.WIDTH($bits(range_t)), .DEPTH(MAX_STRIPS)) u_ranges (
    .clk, .we(wr_en && q_req.req_type == REQ_STRIP), .waddr(q_req.idx[STRIP_AW-1:0]),
    .wdata(rng_wdata), .raddr(s_r), .rdata(rng_rdata));
  tphq_ram #(.WIDTH(PLATE_AW), .DEPTH(ACCESS_DEPTH)) u_access (
    .clk, .we(wr_en && q_req.req_type == REQ_ACCESS), .waddr(q_req.idx[ACC_AW-1:0]),
    .wdata(q_req.a[PLATE_AW-1:0]), .raddr(acc_raddr), .rdata(acc_rdata));
  tphq_ram #(.WIDTH($bits(plate_t)), .DEPTH(PLATE_DEPTH)) u_plates (
    .clk, .we(wr_en && q_req.req_type == REQ_PLATE), .waddr(q_req.idx[PLATE_AW-1:0]),
    .wdata(plt_wdata), .raddr(acc_rdata), .rdata(plt_rdata));
  tphq_ram #(.WIDTH(64), .DEPTH(POINT_DEPTH)) u_points (
    .clk, .we(wr_en && q_req.req_type == REQ_POINT), .waddr(q_req.idx[POINT_AW-1:0]),
    .wdata({q_req.a, q_req.b}), .raddr(pt_raddr), .rdata(pt_rdata));
  tphq_ram #(.WIDTH(64), .DEPTH(SLOPE_DEPTH)) u_slope_xz (
    .clk, .we(wr_en && q_req.req_type == REQ_SLOPE), .waddr(q_req.idx[SLOPE_AW-1:0]),
    .wdata({q_req.a, q_req.c}), .raddr(plate_r.slope), .rdata(sxz_rdata));
  tphq_ram #(.WIDTH(32), .DEPTH(SLOPE_DEPTH)) u_slope_up (
    .clk, .we(wr_en && q_req.req_type == REQ_SLOPE), .waddr(q_req.idx[SLOPE_AW-1:0]),
    .wdata(q_req.b), .raddr(plate_r.slope), .rdata(sup_rdata));
  tphq_ram #(.WIDTH(32), .DEPTH(PLATE_DEPTH)) u_offsets (
    .clk, .we(wr_en && q_req.req_type == REQ_HEIGHT), .waddr(q_req.idx[PLATE_AW-1:0]),
    .wdata(q_req.a), .raddr(plate_r.height), .rdata(off_rdata));

  // combinational helpers
  logic [BS_W-1:0]    n_eff;
  logic signed [31:0] p1x, p1z, lo_x, hi_x, lo_z, hi_z, sum_w;
  logic               in_box;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [32:0] diff;
  logic [32:0]        cand_dist;

  always_comb begin
    n_eff  = (strip_count > SCNT_W'(MAX_STRIPS)) ? BS_W'(MAX_STRIPS) : BS_W'(strip_count);
    p1x    = $signed(pt_rdata[63:32]);
    p1z    = $signed(pt_rdata[31:0]);
    lo_x   = (pt0x_r <= p1x) ? pt0x_r : p1x;
    hi_x   = (pt0x_r <= p1x) ? p1x : pt0x_r;
    lo_z   = (pt0z_r <= p1z) ? pt0z_r : p1z;
    hi_z   = (pt0z_r <= p1z) ? p1z : pt0z_r;
    in_box = (lo_x <= x_r) && (x_r <= hi_x) && (lo_z <= z_r) && (z_r <= hi_z);
    sum_w  = fx_round(prod1_r) + fx_round(prod2_r) + off_r;
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    rem_ge = rem_sh >= {1'b0, dmag_r};
    diff   = {cand_r[31], cand_r} - {cur_r[31], cur_r};
    cand_dist = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop && q_req.kind == KIND_QUERY) begin
            cur_r   <= q_req.a;
            x_r     <= q_req.b;
            z_r     <= q_req.c;
            state_r <= S_QSTART;
          end
        end
        S_QSTART: begin
          if (!map_loaded || n_eff == '0) begin
            out_valid_r <= 1'b1;
            found_r     <= 1'b0;
            height_r    <= '0;
            state_r     <= S_IDLE;
          end else if (n_eff == BS_W'(1)) begin
            s_r     <= '0;
            state_r <= S_RNG_RD;
          end else begin
            low_r   <= '0;
            high_r  <= n_eff - BS_W'(1);
            mid_r   <= (n_eff - BS_W'(1)) >> 1;
            state_r <= S_BS_RD;
          end
        end
        S_BS_RD: state_r <= S_BS_CMP;
        S_BS_CMP: begin
          if ($signed(bnd_rdata) > z_r) begin
            if ({1'b0, high_r} > {1'b0, low_r} + (BS_W+1)'(1)) begin
              high_r  <= mid_r;
              mid_r   <= BS_W'(({1'b0, low_r} + {1'b0, mid_r}) >> 1);
              state_r <= S_BS_RD;
            end else begin
              s_r     <= mid_r[STRIP_AW-1:0];
              state_r <= S_RNG_RD;
            end
          end else begin
            if ({1'b0, low_r} + (BS_W+1)'(1) < {1'b0, high_r}) begin
              low_r   <= mid_r;
              mid_r   <= BS_W'(({1'b0, mid_r} + {1'b0, high_r}) >> 1);
              state_r <= S_BS_RD;
            end else begin
              s_r     <= STRIP_AW'(mid_r + BS_W'(1));
              state_r <= S_RNG_RD;
            end
          end
        end
        S_RNG_RD: state_r <= S_RNG;
        S_RNG: begin
          start_r <= rng_rdata.start;
          cnt_r   <= rng_rdata.count;
          i_r     <= '0;
          hits_r  <= '0;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (i_r < cnt_r && hits_r < HIT_W'(MAX_CANDIDATES)) begin
            state_r <= S_ACC;
          end else begin
            out_valid_r <= 1'b1;
            found_r     <= (hits_r != '0);
            height_r    <= (hits_r != '0) ? best_r : '0;
            state_r     <= S_IDLE;
          end
        end
        S_ACC: state_r <= S_PLT;
        S_PLT: state_r <= S_PT0;
        S_PT0: begin
          plate_r <= plt_rdata;
          state_r <= S_PT1;
        end
        S_PT1: begin
          pt0x_r  <= $signed(pt_rdata[63:32]);
          pt0z_r  <= $signed(pt_rdata[31:0]);
          state_r <= S_BOX;
        end
        S_BOX: begin
          sx_r  <= $signed(sxz_rdata[63:32]);
          sz_r  <= $signed(sxz_rdata[31:0]);
          sy_r  <= $signed(sup_rdata);
          off_r <= $signed(off_rdata);
          if (in_box) begin
            state_r <= S_MUL1;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_CHK;
          end
        end
        S_MUL1: begin
          prod1_r <= 64'(sx_r) * 64'(x_r);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod2_r <= 64'(sz_r) * 64'(z_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          num_r   <= -sum_w;
          state_r <= S_DIVI;
        end
        S_DIVI: begin
          if (sy_r == 0) begin
            cand_r  <= (num_r > 0) ? 32'sh7FFFFFFF : ((num_r < 0) ? 32'sh80000000 : '0);
            state_r <= S_CAND;
          end else begin
            dvd_r   <= {(num_r[31] ? 32'(-num_r) : 32'(num_r)), 12'd0};
            dmag_r  <= sy_r[31] ? 32'(-sy_r) : 32'(sy_r);
            qneg_r  <= num_r[31] ^ sy_r[31];
            rem_r   <= '0;
            dcnt_r  <= 6'(DVD_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r   <= rem_ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
          dvd_r   <= {dvd_r[DVD_W-2:0], rem_ge};
          dcnt_r  <= dcnt_r - 6'd1;
          if (dcnt_r == '0) state_r <= S_DIVF;
        end
        S_DIVF: begin
          // truncated quotient, saturated to 32 bits
          if (!qneg_r) begin
            cand_r <= (dvd_r[DVD_W-1:31] != '0) ? 32'sh7FFFFFFF : $signed(dvd_r[31:0]);
          end else if (dvd_r[DVD_W-1:32] != '0 || (dvd_r[31] && dvd_r[30:0] != '0)) begin
            cand_r <= 32'sh80000000;
          end else begin
            cand_r <= -$signed(dvd_r[31:0]);
          end
          state_r <= S_CAND;
        end
        S_CAND: begin
          if (hits_r == '0 || cand_dist < best_dist_r) begin
            best_dist_r <= cand_dist;
            best_r      <= cand_r;
          end
          hits_r  <= hits_r + HIT_W'(1);
          i_r     <= i_r + CNT_W'(1);
          state_r <= S_CHK;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.height_found = found_r;
  assign out_ch.new_height   = height_r;
endmodule

[sv/terrain_plane_height_query.sv]
// ---------------------------------------------------------------------------
// terrain_plane_height_query
// collision table store and plane height lookup over strips of plates
// ---------------------------------------------------------------------------
// channels: in_ch takes write items (fill the tables, no result) and query
//   items (one result each); out_ch gives height_found and new_height;
//   cfg_ch writes map_loaded (index 0) and strip_count (index 1), always ready
// a transfer on in_ch lands in a two-entry queue in front of the engine, so
//   input may keep flowing while the engine is busy or a result is waiting
// write items are applied to the tables as they leave the queue, with no result
// a query leaving the queue binary-searches the strip bounds when there are
//   several strips (up to 9 steps), reads the strip's range and scans its
//   plates; each plate that covers the point is solved with two multiplies,
//   one sum and a 44-bit bit-serial divider, skipped when the slope's y is zero;
//   at most 10 covering plates are solved; without a map or strips it fails
// the single query sequencer works on one query at a time; the next query
//   starts once the result register is free
// reset clears the queue, the engine state, the result valid flag and both
//   configuration registers; table contents are undefined until written
// when out_ch stalls the result is held, writes queued behind it still
//   complete, and the next query waits
// ---------------------------------------------------------------------------
module terrain_plane_height_query (
  input logic        clk,
  input logic        rst_n,
  tphq_req_if.sink   in_ch,
  tphq_res_if.source out_ch,
  tphq_cfg_if.sink   cfg_ch
);
  import tphq_pkg::*;

  req_t              q_req;
  logic              q_valid, q_pop;
  logic              map_loaded_r;
  logic [SCNT_W-1:0] strip_count_r;

  // configuration registers, writes taken at any time
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_loaded_r  <= 1'b0;
      strip_count_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MAP_LOADED:  map_loaded_r  <= cfg_ch.data[0];
        CFG_STRIP_COUNT: strip_count_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // front end: accept and classify each transfer
  tphq_front u_front (
    .clk, .rst_n, .in_ch, .q_req, .q_valid, .q_pop
  );

  // back end: tables and query sequencer
  tphq_back u_back (
    .clk, .rst_n, .q_req, .q_valid, .q_pop,
    .map_loaded(map_loaded_r), .strip_count(strip_count_r), .out_ch
  );
endmodule
